// File: design/mzis_pkg.sv
package mzis_pkg;

  // sizing
  localparam int PROGRAMS     = 4;
  localparam int ZONES        = 6;
  localparam int SLOTS        = PROGRAMS + 1;
  localparam int DUR_CAP      = 3600;
  localparam int ROLL_LIMIT   = 100;

  localparam int SLOT_W  = $clog2(SLOTS + 1);
  localparam int ZONE_W  = $clog2(ZONES);
  localparam int ZD_W    = $clog2(SLOTS * ZONES);
  localparam int DUR_W   = $clog2(DUR_CAP + 1);
  localparam int ROLL_W  = $clog2(ROLL_LIMIT + 1);
  localparam int T_W     = 34;
  localparam int STEP_W  = 25;
  localparam int PROD_W  = DUR_W + 9;
  localparam int RECIP_W = 20;
  localparam int Q_W     = 14;
  localparam int COR_W   = 17;
  localparam int CV_W    = 18;

  localparam logic [31:0]        NO_TIME     = 32'h7FFF_FFFF;
  localparam logic [31:0]        TIME_SAT    = 32'hFFFF_FFFF;
  localparam logic [16:0]        DAY_SECONDS = 17'd86400;
  localparam logic [RECIP_W-1:0] RECIP       = 20'd671089;
  localparam int                 RECIP_SHIFT = 26;
  localparam logic [COR_W-1:0]   COR_MAX     = 17'd131070;
  localparam logic [16:0]        CNT_MAX     = 17'h1FFFF;
  localparam logic [3:0]         GAP_MAX     = 4'd10;
  localparam logic [3:0]         GAP_RESET   = 4'd2;

  // configuration register indexes
  localparam logic CFG_CORR = 1'b0;
  localparam logic CFG_GAP  = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_HEADER  = 3'd1,
    OP_ZONE    = 3'd2,
    OP_MANUAL  = 3'd3,
    OP_RUN_NOW = 3'd4,
    OP_CANCEL  = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_EXEC, ST_RC_CLEAR, ST_RC_PROG, ST_ROLL, ST_LY_INIT,
    ST_LY_MUL, ST_LY_DIV, ST_LY_COR, ST_LY_ADD, ST_RC_CMP, ST_RN_COMMIT, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_EXEC, CMD_RC_CLEAR, CMD_PROG_LOAD, CMD_PROG_SKIP,
    CMD_ROLL, CMD_LY_INIT_RC, CMD_LY_INIT_RN, CMD_LY_MUL, CMD_LY_DIV, CMD_LY_COR,
    CMD_LY_ADD, CMD_RC_CMP, CMD_RN_COMMIT, CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic rc_needed;
    logic rn_needed;
    logic prog_active;
    logic prog_manual;
    logic prog_last;
    logic roll_more;
    logic zone_last;
    logic out_free;
  } status_t;

  function automatic logic [31:0] sat32(input logic [T_W-1:0] v);
    return (|v[T_W-1:32]) ? TIME_SAT : v[31:0];
  endfunction

endpackage

// File: design/mzis_ctrl.sv
module mzis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mzis_pkg::status_t st,
  output mzis_pkg::cmd_t    cmd
);
  import mzis_pkg::*;

  state_t state, state_next;
  logic   ret_exec, ret_exec_next;
  logic   rn_mode, rn_mode_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret_exec <= 1'b0;
      rn_mode  <= 1'b0;
    end else begin
      state    <= state_next;
      ret_exec <= ret_exec_next;
      rn_mode  <= rn_mode_next;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    ret_exec_next = ret_exec;
    rn_mode_next  = rn_mode;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        if (st.pending) begin
          ret_exec_next = 1'b1;
          rn_mode_next  = 1'b0;
          state_next    = ST_RC_CLEAR;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ret_exec_next = 1'b0;
        if (st.rc_needed) begin
          rn_mode_next = 1'b0;
          state_next   = ST_RC_CLEAR;
        end else if (st.rn_needed) begin
          rn_mode_next = 1'b1;
          state_next   = ST_LY_INIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RC_CLEAR: state_next = ST_RC_PROG;
      ST_RC_PROG: begin
        if (!st.prog_active) begin
          if (st.prog_last) state_next = ret_exec ? ST_EXEC : ST_DONE;
        end else if (st.prog_manual) begin
          state_next = ST_LY_INIT;
        end else begin
          state_next = ST_ROLL;
        end
      end
      ST_ROLL: begin
        if (!st.roll_more) state_next = ST_LY_INIT;
      end
      ST_LY_INIT: state_next = ST_LY_MUL;
      ST_LY_MUL:  state_next = ST_LY_DIV;
      ST_LY_DIV:  state_next = ST_LY_COR;
      ST_LY_COR:  state_next = ST_LY_ADD;
      ST_LY_ADD: begin
        if (st.zone_last) state_next = rn_mode ? ST_RN_COMMIT : ST_RC_CMP;
        else state_next = ST_LY_MUL;
      end
      ST_RC_CMP: begin
        if (st.prog_last) state_next = ret_exec ? ST_EXEC : ST_DONE;
        else state_next = ST_RC_PROG;
      end
      ST_RN_COMMIT: state_next = ST_DONE;
      ST_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      ST_START:    cmd = CMD_NONE;
      ST_EXEC:     cmd = CMD_EXEC;
      ST_RC_CLEAR: cmd = CMD_RC_CLEAR;
      ST_RC_PROG: begin
        if (!st.prog_active) cmd = st.prog_last ? CMD_NONE : CMD_PROG_SKIP;
        else cmd = CMD_PROG_LOAD;
      end
      ST_ROLL:      cmd = CMD_ROLL;
      ST_LY_INIT:   cmd = rn_mode ? CMD_LY_INIT_RN : CMD_LY_INIT_RC;
      ST_LY_MUL:    cmd = CMD_LY_MUL;
      ST_LY_DIV:    cmd = CMD_LY_DIV;
      ST_LY_COR:    cmd = CMD_LY_COR;
      ST_LY_ADD:    cmd = CMD_LY_ADD;
      ST_RC_CMP:    cmd = CMD_RC_CMP;
      ST_RN_COMMIT: cmd = CMD_RN_COMMIT;
      ST_DONE: begin
        if (st.out_free) cmd = CMD_OUT_LOAD;
      end
      default: cmd = CMD_NONE;
    endcase
  end

endmodule

// File: design/mzis_datapath.sv
module mzis_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mzis_pkg::cmd_t    cmd,
  output mzis_pkg::status_t st,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [2:0]        opcode,
  input  logic [31:0]       now_seconds,
  input  logic [2:0]        program_index,
  input  logic [2:0]        zone_index,
  input  logic [15:0]       duration,
  input  logic              program_active,
  input  logic [31:0]       first_start,
  input  logic [7:0]        repeat_period,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        relay_zone,
  output logic [2:0]        running_zone,
  output logic [16:0]       countdown,
  output logic              in_schedule,
  output logic [31:0]       next_start,
  output logic [31:0]       next_end
);
  import mzis_pkg::*;

  // configuration
  logic signed [7:0] corr;
  logic [3:0]        gap;
  logic              pending;

  // latched item
  logic [2:0]  op_r;
  logic [31:0] now_r;
  logic [2:0]  pi_r;
  logic [2:0]  zi_r;
  logic [15:0] dur_r;
  logic        act_r;
  logic [31:0] start_r;
  logic [7:0]  rep_r;

  // program table
  logic              prog_active [SLOTS];
  logic [31:0]       prog_start  [SLOTS];
  logic [7:0]        prog_repeat [SLOTS];
  logic [DUR_W-1:0]  zone_dur    [SLOTS*ZONES];

  // schedule
  logic [31:0] sz_start [ZONES];
  logic [31:0] sz_end   [ZONES];
  logic        sz_on    [ZONES];
  logic [31:0] sched_start;
  logic [31:0] sched_end;
  logic [2:0]  relay;

  // layout scratch
  logic [31:0] ws [ZONES];
  logic [31:0] we [ZONES];
  logic        won [ZONES];

  // working registers
  logic [SLOT_W-1:0]        p_r;
  logic [ZONE_W-1:0]        z_r;
  logic [T_W-1:0]           t_r;
  logic [ROLL_W-1:0]        n_r;
  logic [STEP_W-1:0]        step_r;
  logic [T_W-1:0]           lt_r;
  logic [31:0]              lend_r;
  logic [DUR_W-1:0]         d_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]           q_r;
  logic                     neg_r;
  logic [COR_W-1:0]         cd_r;
  logic [2:0]               run_r;
  logic [16:0]              cnt_r;

  // combinational helpers
  logic [ZD_W-1:0]          rd_idx;
  logic [ZD_W-1:0]          wr_idx;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W+RECIP_W-1:0] qprod;
  logic signed [CV_W-1:0]   cv;
  logic [T_W-1:0]           we_sum;
  logic [31:0]              we_sat;
  logic [T_W-1:0]           now2;
  logic [T_W-1:0]           now1;
  logic                     hit_found;
  logic [ZONE_W-1:0]        hit_idx;
  logic                     relay_clr;
  logic                     hit_z;
  logic [31:0]              left;
  logic                     pi_prog;
  logic                     pi_slot;
  logic                     zi_ok;

  assign cfg_ready = 1'b1;

  assign pi_prog = (pi_r < 3'(PROGRAMS));
  assign pi_slot = (pi_r < 3'(SLOTS));
  assign zi_ok   = (zi_r < 3'(ZONES));
  assign rd_idx  = ZD_W'(p_r * ZONES) + ZD_W'(z_r);
  assign wr_idx  = ZD_W'(pi_r * ZONES) + ZD_W'(zi_r);
  assign now2    = T_W'(now_r) + T_W'(2);
  assign now1    = T_W'(now_r) + T_W'(1);

  // divide by 100 via reciprocal
  assign mag   = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign qprod = (PROD_W+RECIP_W)'(mag) * (PROD_W+RECIP_W)'(RECIP);

  // corrected duration before clamp
  assign cv = $signed({{(CV_W-DUR_W){1'b0}}, d_r}) +
              (neg_r ? -$signed({{(CV_W-Q_W){1'b0}}, q_r})
                     :  $signed({{(CV_W-Q_W){1'b0}}, q_r}));

  assign we_sum = lt_r + T_W'(cd_r);
  assign we_sat = sat32(we_sum);

  // zone window search for a tick
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    relay_clr = 1'b0;
    hit_z     = 1'b0;
    for (int z = 0; z < ZONES; z++) begin
      hit_z = sz_on[z] && (sz_start[z] <= now_r) && (now_r < sz_end[z]);
      if (!hit_found) begin
        if (hit_z) begin
          hit_found = 1'b1;
          hit_idx   = ZONE_W'(z);
        end else if (sz_on[z] && relay == 3'(z + 1)) begin
          relay_clr = 1'b1;
        end
      end
    end
  end

  assign left = sz_end[hit_idx] - now_r;

  // status toward the controller
  always_comb begin
    st.pending     = pending;
    st.rc_needed   = 1'b0;
    st.rn_needed   = 1'b0;
    case (op_r)
      OP_TICK:    st.rc_needed = (now_r > sched_end);
      OP_HEADER:  st.rc_needed = pi_prog;
      OP_ZONE:    st.rc_needed = pi_slot && zi_ok;
      OP_MANUAL:  st.rc_needed = 1'b1;
      OP_CANCEL:  st.rc_needed = 1'b1;
      OP_RUN_NOW: st.rn_needed = pi_prog && prog_active[pi_r];
      default:    st.rc_needed = 1'b0;
    endcase
    st.prog_active = (p_r < SLOT_W'(SLOTS)) && prog_active[p_r];
    st.prog_manual = (p_r == SLOT_W'(PROGRAMS));
    st.prog_last   = (p_r == SLOT_W'(SLOTS - 1));
    st.roll_more   = (t_r < T_W'(now_r)) && (n_r < ROLL_W'(ROLL_LIMIT));
    st.zone_last   = (z_r == ZONE_W'(ZONES - 1));
    st.out_free    = !out_valid || out_ready;
  end

  // configuration writes and pending recompute
  always_ff @(posedge clk) begin
    if (rst) begin
      corr    <= '0;
      gap     <= GAP_RESET;
      pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CORR) begin
          if ($signed(cfg_data) != corr) begin
            corr    <= $signed(cfg_data);
            pending <= 1'b1;
          end
        end else if (cfg_data[3:0] <= GAP_MAX) begin
          gap     <= cfg_data[3:0];
          pending <= 1'b1;
        end
      end else if (cmd == CMD_RC_CLEAR) begin
        pending <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      op_r    <= opcode;
      now_r   <= now_seconds;
      pi_r    <= program_index;
      zi_r    <= zone_index;
      dur_r   <= duration;
      act_r   <= program_active;
      start_r <= first_start;
      rep_r   <= repeat_period;
    end
  end

  // program table, schedule and relay
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        prog_active[i] <= 1'b0;
        prog_start[i]  <= '0;
        prog_repeat[i] <= 8'd1;
      end
      for (int i = 0; i < SLOTS * ZONES; i++) zone_dur[i] <= '0;
      for (int i = 0; i < ZONES; i++) begin
        sz_start[i] <= NO_TIME;
        sz_end[i]   <= '0;
        sz_on[i]    <= 1'b0;
      end
      sched_start <= NO_TIME;
      sched_end   <= '0;
      relay       <= '0;
    end else begin
      unique case (cmd)
        CMD_EXEC: begin
          case (op_r)
            OP_TICK: begin
              if (hit_found) relay <= 3'(hit_idx) + 3'd1;
              else if (relay_clr) relay <= '0;
              if (now_r > sched_end) prog_active[PROGRAMS] <= 1'b0;
            end
            OP_HEADER: begin
              if (pi_prog) begin
                prog_active[pi_r] <= act_r;
                prog_start[pi_r]  <= start_r;
                prog_repeat[pi_r] <= rep_r;
              end
            end
            OP_ZONE: begin
              if (pi_slot && zi_ok) begin
                zone_dur[wr_idx] <= (dur_r > 16'(DUR_CAP)) ?
                                    DUR_W'(DUR_CAP) : DUR_W'(dur_r);
              end
            end
            OP_MANUAL: begin
              prog_active[PROGRAMS] <= 1'b1;
              prog_repeat[PROGRAMS] <= 8'd1;
              prog_start[PROGRAMS]  <= sat32(now1);
            end
            OP_CANCEL: begin
              prog_active[PROGRAMS] <= 1'b0;
              relay                 <= '0;
            end
            default: ;
          endcase
        end
        CMD_RC_CLEAR: begin
          for (int i = 0; i < ZONES; i++) begin
            sz_start[i] <= NO_TIME;
            sz_end[i]   <= '0;
            sz_on[i]    <= 1'b0;
          end
          sched_start <= NO_TIME;
          sched_end   <= '0;
        end
        CMD_ROLL: begin
          if (!st.roll_more) prog_start[p_r] <= sat32(t_r);
        end
        CMD_RC_CMP: begin
          if (sched_start > prog_start[p_r]) begin
            for (int i = 0; i < ZONES; i++) begin
              sz_start[i] <= ws[i];
              sz_end[i]   <= we[i];
              sz_on[i]    <= won[i];
            end
            sched_start <= prog_start[p_r];
            sched_end   <= lend_r;
          end
        end
        CMD_RN_COMMIT: begin
          for (int i = 0; i < ZONES; i++) begin
            sz_start[i] <= ws[i];
            sz_end[i]   <= we[i];
            sz_on[i]    <= won[i];
          end
          sched_start <= sat32(now2);
          sched_end   <= lend_r;
        end
        default: ;
      endcase
    end
  end

  // roll forward and zone layout
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_RC_CLEAR:  p_r <= '0;
      CMD_PROG_SKIP: p_r <= p_r + SLOT_W'(1);
      CMD_PROG_LOAD: begin
        t_r    <= T_W'(prog_start[p_r]);
        n_r    <= '0;
        step_r <= STEP_W'(DAY_SECONDS) * STEP_W'(prog_repeat[p_r]);
      end
      CMD_ROLL: begin
        if (st.roll_more) begin
          t_r <= t_r + T_W'(step_r);
          n_r <= n_r + ROLL_W'(1);
        end
      end
      CMD_LY_INIT_RC: begin
        lt_r   <= T_W'(prog_start[p_r]);
        lend_r <= '0;
        z_r    <= '0;
      end
      CMD_LY_INIT_RN: begin
        p_r    <= SLOT_W'(pi_r);
        lt_r   <= now2;
        lend_r <= sat32(now2);
        z_r    <= '0;
      end
      CMD_LY_MUL: begin
        d_r    <= zone_dur[rd_idx];
        prod_r <= PROD_W'($signed({1'b0, zone_dur[rd_idx]}) * corr);
      end
      CMD_LY_DIV: begin
        q_r   <= Q_W'(qprod >> RECIP_SHIFT);
        neg_r <= prod_r[PROD_W-1];
      end
      CMD_LY_COR: begin
        if (cv < 0) cd_r <= '0;
        else if (cv > $signed({1'b0, COR_MAX})) cd_r <= COR_MAX;
        else cd_r <= COR_W'(cv);
      end
      CMD_LY_ADD: begin
        if (d_r == '0) begin
          ws[z_r]  <= NO_TIME;
          we[z_r]  <= '0;
          won[z_r] <= 1'b0;
        end else begin
          ws[z_r]  <= sat32(lt_r);
          we[z_r]  <= we_sat;
          won[z_r] <= 1'b1;
          lt_r     <= we_sum + T_W'(gap);
          if (we_sat > lend_r) lend_r <= we_sat;
        end
        z_r <= z_r + ZONE_W'(1);
      end
      CMD_RC_CMP: p_r <= p_r + SLOT_W'(1);
      default: ;
    endcase
  end

  // per-item tick result
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      run_r <= '0;
      cnt_r <= '0;
    end else if (cmd == CMD_EXEC && op_r == OP_TICK && hit_found) begin
      run_r <= 3'(hit_idx) + 3'd1;
      cnt_r <= (left > 32'(CNT_MAX)) ? CNT_MAX : left[16:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_OUT_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT_LOAD) begin
      relay_zone   <= relay;
      running_zone <= run_r;
      countdown    <= cnt_r;
      in_schedule  <= (now_r >= sched_start) && (now_r < sched_end);
      next_start   <= sched_start;
      next_end     <= sched_end;
    end
  end

endmodule

// File: design/multi_zone_irrigation_sequencer_top.sv
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | opcode, now_seconds, program_index, ...
// out      | out_valid / out_ready | relay_zone, running_zone, countdown, ...
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. An accepted item passes a start, an execute and a result
// step. A recompute adds a clear step, a skip step per idle slot and, per active
// slot, a load, roll steps (at most ROLL_LIMIT advances, none for the manual slot),
// a layout init, multiply, divide, correct and add steps per zone, and a compare.
// A pending config change can add a second recompute.
// Synchronous reset clears the program table and schedule at once.
// A result waits in the output register; the next item is accepted meanwhile.
module multi_zone_irrigation_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] now_seconds,
  input  logic [2:0]  program_index,
  input  logic [2:0]  zone_index,
  input  logic [15:0] duration,
  input  logic        program_active,
  input  logic [31:0] first_start,
  input  logic [7:0]  repeat_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  relay_zone,
  output logic [2:0]  running_zone,
  output logic [16:0] countdown,
  output logic        in_schedule,
  output logic [31:0] next_start,
  output logic [31:0] next_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import mzis_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  mzis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // tables, layout unit and result register
  mzis_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .now_seconds    (now_seconds),
    .program_index  (program_index),
    .zone_index     (zone_index),
    .duration       (duration),
    .program_active (program_active),
    .first_start    (first_start),
    .repeat_period  (repeat_period),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .relay_zone     (relay_zone),
    .running_zone   (running_zone),
    .countdown      (countdown),
    .in_schedule    (in_schedule),
    .next_start     (next_start),
    .next_end       (next_end)
  );

endmodule
